// ===== rtl/sfcb_pkg.sv =====
// Package with shared types, constants and state encodings for the code builder.
package sfcb_pkg;

	localparam int MaxSymbolsDef = 16;
	localparam int CountWidthDef = 16;
	localparam int CodeMaxLen    = 15;
	localparam int CodeLenW      = 4;
	localparam int SymIdxW       = 4;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT,
		ST_INIT,
		ST_POP,
		ST_SUM,
		ST_SEARCH,
		ST_APPLY,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic sort_step;
		logic init;
		logic pop;
		logic sum_step;
		logic search_step;
		logic apply;
		logic emit_start;
		logic emit_take;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic sort_done;
		logic stack_empty;
		logic range_trivial;
		logic sum_done;
		logic search_done;
		logic emit_last;
	} sts_t;

endpackage

// ===== rtl/sfcb_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface sfcb_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sfcb_ctrl.sv =====
// Controller state machine sequencing load, sort, split and emit phases.
module sfcb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output sfcb_pkg::cmd_t  cmd,
	input  sfcb_pkg::sts_t  sts
);
	import sfcb_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (in_valid && in_last) state_d = ST_SORT;
			ST_SORT:   if (sts.sort_done) state_d = ST_INIT;
			ST_INIT:   state_d = ST_POP;
			ST_POP: begin
				if (sts.stack_empty) state_d = ST_EMIT;
				else if (!sts.range_trivial) state_d = ST_SUM;
			end
			ST_SUM:    if (sts.sum_done) state_d = ST_SEARCH;
			ST_SEARCH: if (sts.search_done) state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_POP;
			ST_EMIT:   if (out_ready && sts.emit_last) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SORT:   cmd.sort_step = 1'b1;
			ST_INIT:   cmd.init = 1'b1;
			ST_POP: begin
				cmd.pop        = !sts.stack_empty;
				cmd.emit_start = sts.stack_empty;
			end
			ST_SUM:    cmd.sum_step = 1'b1;
			ST_SEARCH: cmd.search_step = 1'b1;
			ST_APPLY:  cmd.apply = 1'b1;
			ST_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit_take = out_ready;
			end
			default: ;
		endcase
	end

	// Results are only shown in the emit phase and inputs only taken while loading.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output active together");
	a_last_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_ready && sts.emit_last) |=> state_q == ST_LOAD)
		else $error("emit did not end");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && in_valid && in_last) |=> state_q == ST_SORT)
		else $error("coding did not start");
endmodule

// ===== rtl/sfcb_dp.sv =====
// Datapath: symbol stores, bubble sorter, range stack, split search and code stores.
module sfcb_dp #(
	parameter int MAX_SYMBOLS = sfcb_pkg::MaxSymbolsDef,
	parameter int COUNT_WIDTH = sfcb_pkg::CountWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfcb_pkg::cmd_t                cmd,
	output sfcb_pkg::sts_t                sts,
	input  logic [15:0]                   in_count,
	output logic [sfcb_pkg::SymIdxW-1:0]  out_index,
	output logic [sfcb_pkg::CodeMaxLen-1:0] out_code,
	output logic [sfcb_pkg::CodeLenW-1:0] out_len,
	output logic                          out_final
);
	import sfcb_pkg::*;

	localparam int IW  = $clog2(MAX_SYMBOLS);
	localparam int NW  = $clog2(MAX_SYMBOLS + 1);
	localparam int SW  = COUNT_WIDTH + NW;
	localparam int SPW = $clog2(MAX_SYMBOLS + 3);

	logic [COUNT_WIDTH-1:0] cnt_q [MAX_SYMBOLS];
	logic [IW-1:0]          idx_q [MAX_SYMBOLS];
	logic [CodeMaxLen-1:0]  code_q [MAX_SYMBOLS];
	logic [CodeLenW-1:0]    len_q [MAX_SYMBOLS];
	logic [NW-1:0]          n_q;
	logic [IW-1:0]          pos_q;
	logic [NW-1:0]          pass_q;

	logic [IW-1:0]          stk_lo_q [MAX_SYMBOLS + 2];
	logic [IW-1:0]          stk_hi_q [MAX_SYMBOLS + 2];
	logic [SPW-1:0]         sp_q;
	logic [IW-1:0]          lo_q, hi_q, k_q, split_q;
	logic [SW-1:0]          tot_q, low_q, best_q;
	logic [IW-1:0]          ptr_q;

	logic [COUNT_WIDTH-1:0] cin;
	logic [IW-1:0]          top_lo, top_hi;
	logic [SW-1:0]          cur_low, cur_up, d_new, new_low;
	logic                   sweep_end;

	assign cin    = COUNT_WIDTH >= 16 ? COUNT_WIDTH'(in_count)
	                                  : COUNT_WIDTH'(in_count[15:0]);
	assign top_lo = stk_lo_q[sp_q - SPW'(1)];
	assign top_hi = stk_hi_q[sp_q - SPW'(1)];
	assign sweep_end = (NW'(pos_q) + NW'(2) >= n_q);

	// Lower sum after moving the boundary down one entry, and the resulting difference.
	assign new_low = low_q - SW'(cnt_q[k_q]);
	assign cur_low = new_low;
	assign cur_up  = tot_q - new_low;
	assign d_new   = cur_low >= cur_up ? cur_low - cur_up : cur_up - cur_low;

	// Status.
	always_comb begin
		sts.sort_done     = (n_q <= NW'(1)) || (pass_q + NW'(1) >= n_q && sweep_end);
		sts.stack_empty   = (sp_q == '0);
		sts.range_trivial = !(top_lo < top_hi && IW'(top_lo + IW'(1)) != top_hi)
		                    || top_lo >= top_hi;
		sts.sum_done      = (ptr_q == hi_q);
		sts.search_done   = (k_q == lo_q) || (d_new >= best_q);
		sts.emit_last     = (ptr_q == '0);
	end

	assign out_index = SymIdxW'(idx_q[ptr_q]);
	assign out_code  = code_q[ptr_q];
	assign out_len   = len_q[ptr_q];
	assign out_final = (ptr_q == '0);

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			pos_q   <= '0;
			pass_q  <= '0;
			sp_q    <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.load && n_q < NW'(MAX_SYMBOLS)) n_q <= n_q + NW'(1);
			if (cmd.load) begin
				pos_q  <= '0;
				pass_q <= NW'(1);
			end
			if (cmd.sort_step) begin
				if (sweep_end) begin
					pos_q  <= '0;
					pass_q <= pass_q + NW'(1);
				end else begin
					pos_q <= pos_q + IW'(1);
				end
			end
			if (cmd.init) sp_q <= SPW'(1);
			if (cmd.pop) begin
				sp_q <= sp_q - SPW'(1);
				ptr_q <= top_lo;
			end
			if (cmd.sum_step && ptr_q != hi_q) ptr_q <= ptr_q + IW'(1);
			if (cmd.apply) sp_q <= sp_q + SPW'(2);
			// Results leave from the largest count downward.
			if (cmd.emit_start) ptr_q <= IW'(n_q - NW'(1));
			if (cmd.emit_take) begin
				ptr_q <= ptr_q - IW'(1);
				if (ptr_q == '0) n_q <= '0;
			end
		end
	end

	// Stores, stack and search registers.
	always_ff @(posedge clk) begin
		if (cmd.load && n_q < NW'(MAX_SYMBOLS)) begin
			cnt_q[IW'(n_q)] <= cin;
			idx_q[IW'(n_q)] <= IW'(n_q);
		end
		if (cmd.sort_step && n_q > NW'(1) && cnt_q[pos_q] > cnt_q[pos_q + IW'(1)]) begin
			cnt_q[pos_q]         <= cnt_q[pos_q + IW'(1)];
			cnt_q[pos_q + IW'(1)] <= cnt_q[pos_q];
			idx_q[pos_q]         <= idx_q[pos_q + IW'(1)];
			idx_q[pos_q + IW'(1)] <= idx_q[pos_q];
		end
		if (cmd.init) begin
			for (int i = 0; i < MAX_SYMBOLS; i++) begin
				code_q[i] <= '0;
				len_q[i]  <= '0;
			end
			stk_lo_q[0] <= '0;
			stk_hi_q[0] <= IW'(n_q - NW'(1));
		end
		if (cmd.pop) begin
			lo_q  <= top_lo;
			hi_q  <= top_hi;
			tot_q <= '0;
			if (top_lo + IW'(1) == top_hi && top_lo < top_hi) begin
				if (len_q[top_lo] < CodeLenW'(CodeMaxLen)) begin
					code_q[top_lo] <= {code_q[top_lo][CodeMaxLen-2:0], 1'b1};
					len_q[top_lo]  <= len_q[top_lo] + CodeLenW'(1);
				end
				if (len_q[top_hi] < CodeLenW'(CodeMaxLen)) begin
					code_q[top_hi] <= {code_q[top_hi][CodeMaxLen-2:0], 1'b0};
					len_q[top_hi]  <= len_q[top_hi] + CodeLenW'(1);
				end
			end
		end
		// Accumulate the range total one entry per cycle.
		if (cmd.sum_step) begin
			tot_q <= tot_q + SW'(cnt_q[ptr_q]);
			if (ptr_q == hi_q) begin
				low_q   <= tot_q + SW'(cnt_q[ptr_q]) - SW'(cnt_q[hi_q]);
				best_q  <= (tot_q + SW'(cnt_q[ptr_q]) - SW'(cnt_q[hi_q])) >= SW'(cnt_q[hi_q])
				           ? tot_q + SW'(cnt_q[ptr_q]) - SW'(cnt_q[hi_q]) - SW'(cnt_q[hi_q])
				           : SW'(cnt_q[hi_q]) - (tot_q + SW'(cnt_q[ptr_q]) - SW'(cnt_q[hi_q]));
				k_q     <= hi_q - IW'(1);
				split_q <= hi_q - IW'(1);
			end
		end
		// Move the boundary down while the imbalance strictly falls.
		if (cmd.search_step && !sts.search_done) begin
			low_q   <= new_low;
			best_q  <= d_new;
			k_q     <= k_q - IW'(1);
			split_q <= k_q - IW'(1);
		end
		// Append one bit to every entry of the range; push the upper part, then the lower.
		if (cmd.apply) begin
			for (int i = 0; i < MAX_SYMBOLS; i++) begin
				if (IW'(i) >= lo_q && IW'(i) <= hi_q && len_q[i] < CodeLenW'(CodeMaxLen)) begin
					code_q[i] <= {code_q[i][CodeMaxLen-2:0], IW'(i) <= split_q};
					len_q[i]  <= len_q[i] + CodeLenW'(1);
				end
			end
			stk_lo_q[sp_q]          <= split_q + IW'(1);
			stk_hi_q[sp_q]          <= hi_q;
			stk_lo_q[sp_q + SPW'(1)] <= lo_q;
			stk_hi_q[sp_q + SPW'(1)] <= split_q;
		end
	end

	// Stack depth never exceeds MAX_SYMBOLS.
	a_sp: assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SPW'(MAX_SYMBOLS))
		else $error("range stack overflow");
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> (split_q >= lo_q && split_q < hi_q))
		else $error("split out of range");
	a_n: assert property (@(posedge clk) disable iff (!arst_n) n_q <= NW'(MAX_SYMBOLS))
		else $error("symbol count overflow");
endmodule

// ===== rtl/shannon_fano_code_builder.sv =====
// Top level of the code builder: controller, datapath and channel wiring.
// Sequence: counts are taken one transaction per cycle; after the last count the
// counts are sorted, the range stack is set up and ranges are popped in turn;
// a range of L>=3 entries is summed, searched for its split and applied. When a pop
// finds the stack empty, n results leave one per cycle while out_ready is high,
// largest count first. Input waits until the last result is taken.
// Reset (arst_n low) empties the store and returns the controller to loading.
module shannon_fano_code_builder #(
	parameter int MAX_SYMBOLS = sfcb_pkg::MaxSymbolsDef,
	parameter int COUNT_WIDTH = sfcb_pkg::CountWidthDef
) (
	input logic clk,
	input logic arst_n,
	sfcb_if.sink   sym_in,
	sfcb_if.source code_out
);
	import sfcb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sfcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sym_in.valid),
		.in_last   (sym_in.data.last_symbol),
		.in_ready  (sym_in.ready),
		.out_valid (code_out.valid),
		.out_ready (code_out.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sfcb_dp #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_count  (sym_in.data.symbol_count),
		.out_index (code_out.data.symbol_index),
		.out_code  (code_out.data.code_bits),
		.out_len   (code_out.data.code_length),
		.out_final (code_out.data.final_code)
	);
endmodule
